// ----- sv/qtrm_pkg.sv -----
// qtrm_pkg: widths and types shared by the quaternion to rotation matrix block
// used by qtrm_front, qtrm_div_cell, quaternion_to_rotation_matrix, qtrm_checker and the testbench
`timescale 1ns / 1ps
package qtrm_pkg;
    localparam int OUT_W   = 16;   // one matrix entry on the output bus
    localparam int N_ENTRY = 9;    // entries of the 3x3 matrix
    localparam int C_W     = 17;   // signed component after range reduction
    localparam int PROD_W  = 34;   // signed product of two components
    localparam int NUM_W   = 36;   // signed numerator of one entry
    localparam int N_W     = 33;   // unsigned squared norm, also entry magnitude
    localparam logic [31:0] MAG_LIMIT = 32'd32768;

    typedef logic [N_W-1:0] t_mag;
endpackage

// ----- sv/qtrm_front.sv -----
// qtrm_front: range reduction, products, numerators and dividend set-up
// depends on qtrm_pkg
`timescale 1ns / 1ps
module qtrm_front
    import qtrm_pkg::*;
#(
    parameter int IN_WIDTH  = 16,
    parameter int FRAC_BITS = 14
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [IN_WIDTH-1:0]      i_w,
    input  logic [IN_WIDTH-1:0]      i_x,
    input  logic [IN_WIDTH-1:0]      i_y,
    input  logic [IN_WIDTH-1:0]      i_z,
    output t_mag                     o_n,
    output t_mag                     o_rem  [N_ENTRY],
    output logic [FRAC_BITS:0]       o_low  [N_ENTRY],
    output logic [N_ENTRY-1:0]       o_neg
);
    localparam int MAXSH = (IN_WIDTH > 16) ? IN_WIDTH - 16 : 0;
    localparam int SH_W  = $clog2(MAXSH + 2);
    localparam int DW    = N_W + FRAC_BITS + 1;

    // stage 1: magnitudes and the largest of them
    logic [IN_WIDTH-1:0] r_mag [4];
    logic [3:0]          r_sgn;
    logic [IN_WIDTH-1:0] r_mx;
    logic [IN_WIDTH-1:0] w_in  [4];
    logic [IN_WIDTH-1:0] w_mg  [4];
    logic [IN_WIDTH-1:0] w_mx;

    always_comb begin
        w_in[0] = i_w;
        w_in[1] = i_x;
        w_in[2] = i_y;
        w_in[3] = i_z;
        w_mx = '0;
        for (int i = 0; i < 4; i++) begin
            w_mg[i] = w_in[i][IN_WIDTH-1] ? (~w_in[i] + 1'b1) : w_in[i];
            if (w_mg[i] > w_mx) begin
                w_mx = w_mg[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r_mag[i] <= w_mg[i];
                r_sgn[i] <= w_in[i][IN_WIDTH-1];
            end
            r_mx <= w_mx;
        end
    end

    // stage 2: shift all components together until they fit 16 bits of magnitude
    logic signed [C_W-1:0] r_c [4];
    logic [SH_W-1:0]       w_sh;
    logic [IN_WIDTH-1:0]   w_smag;
    logic [C_W-1:0]        w_cm [4];

    always_comb begin
        w_sh = '0;
        for (int s = MAXSH; s >= 0; s--) begin
            if (32'(r_mx >> s) <= MAG_LIMIT) begin
                w_sh = SH_W'(s);
            end
        end
        for (int i = 0; i < 4; i++) begin
            w_smag = r_mag[i] >> w_sh;
            w_cm[i] = C_W'(w_smag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r_c[i] <= r_sgn[i] ? -$signed(w_cm[i]) : $signed(w_cm[i]);
            end
        end
    end

    // stage 3: ten products
    logic signed [PROD_W-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_xw, r_yw, r_zw;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ww <= r_c[0] * r_c[0];
            r_xx <= r_c[1] * r_c[1];
            r_yy <= r_c[2] * r_c[2];
            r_zz <= r_c[3] * r_c[3];
            r_xy <= r_c[1] * r_c[2];
            r_xz <= r_c[1] * r_c[3];
            r_yz <= r_c[2] * r_c[3];
            r_xw <= r_c[1] * r_c[0];
            r_yw <= r_c[2] * r_c[0];
            r_zw <= r_c[3] * r_c[0];
        end
    end

    // stage 4: numerators as magnitude and sign, and the norm
    logic signed [NUM_W-1:0] w_num [N_ENTRY];
    logic signed [NUM_W-1:0] w_ww, w_xx, w_yy, w_zz, w_xy, w_xz, w_yz, w_xw, w_yw, w_zw;
    logic [NUM_W-1:0]        w_abs [N_ENTRY];
    t_mag                    r_nmag [N_ENTRY];
    logic [N_ENTRY-1:0]      r_nneg;
    t_mag                    r_n4;
    logic [NUM_W-1:0]        w_nsum;

    always_comb begin
        w_ww = NUM_W'(r_ww);
        w_xx = NUM_W'(r_xx);
        w_yy = NUM_W'(r_yy);
        w_zz = NUM_W'(r_zz);
        w_xy = NUM_W'(r_xy);
        w_xz = NUM_W'(r_xz);
        w_yz = NUM_W'(r_yz);
        w_xw = NUM_W'(r_xw);
        w_yw = NUM_W'(r_yw);
        w_zw = NUM_W'(r_zw);
        w_num[0] = w_ww + w_xx - w_yy - w_zz;
        w_num[1] = (w_xy - w_zw) <<< 1;
        w_num[2] = (w_xz + w_yw) <<< 1;
        w_num[3] = (w_xy + w_zw) <<< 1;
        w_num[4] = w_ww - w_xx + w_yy - w_zz;
        w_num[5] = (w_yz - w_xw) <<< 1;
        w_num[6] = (w_xz - w_yw) <<< 1;
        w_num[7] = (w_yz + w_xw) <<< 1;
        w_num[8] = w_ww - w_xx - w_yy + w_zz;
        for (int i = 0; i < N_ENTRY; i++) begin
            w_abs[i] = w_num[i][NUM_W-1] ? (~w_num[i] + 1'b1) : w_num[i];
        end
        w_nsum = w_ww + w_xx + w_yy + w_zz;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < N_ENTRY; i++) begin
                r_nmag[i] <= w_abs[i][N_W-1:0];
                r_nneg[i] <= w_num[i][NUM_W-1];
            end
            r_n4 <= w_nsum[N_W-1:0];
        end
    end

    // stage 5: dividend = mag * 2^frac + n/2, split into top remainder and low bits
    logic [DW-1:0] w_d [N_ENTRY];
    t_mag          r_rem [N_ENTRY];
    logic [FRAC_BITS:0] r_low [N_ENTRY];
    logic [N_ENTRY-1:0] r_neg;
    t_mag          r_n;

    always_comb begin
        for (int i = 0; i < N_ENTRY; i++) begin
            w_d[i] = (DW'(r_nmag[i]) << FRAC_BITS) + DW'(r_n4 >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < N_ENTRY; i++) begin
                r_rem[i] <= w_d[i][DW-1:FRAC_BITS+1];
                r_low[i] <= w_d[i][FRAC_BITS:0];
            end
            r_neg <= r_nneg;
            r_n   <= r_n4;
        end
    end

    assign o_n   = r_n;
    assign o_rem = r_rem;
    assign o_low = r_low;
    assign o_neg = r_neg;
endmodule

// ----- sv/qtrm_div_cell.sv -----
// qtrm_div_cell: one restoring-division step for one matrix entry
// depends on qtrm_pkg
`timescale 1ns / 1ps
module qtrm_div_cell
    import qtrm_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  t_mag               i_n,
    input  t_mag               i_rem,
    input  logic [FRAC_BITS:0] i_low,
    input  logic [FRAC_BITS:0] i_q,
    input  logic               i_neg,
    output t_mag               o_n,
    output t_mag               o_rem,
    output logic [FRAC_BITS:0] o_low,
    output logic [FRAC_BITS:0] o_q,
    output logic               o_neg
);
    logic [N_W:0] w_trial;
    logic [N_W:0] w_diff;
    logic         w_take;

    always_comb begin
        w_trial = {i_rem, i_low[FRAC_BITS]};
        w_diff  = w_trial - {1'b0, i_n};
        w_take  = (w_trial >= {1'b0, i_n});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_n   <= i_n;
            o_rem <= w_take ? w_diff[N_W-1:0] : w_trial[N_W-1:0];
            o_low <= i_low << 1;
            o_q   <= {i_q[FRAC_BITS-1:0], w_take};
            o_neg <= i_neg;
        end
    end
endmodule

// ----- sv/quaternion_to_rotation_matrix.sv -----
// quaternion_to_rotation_matrix: top level, front stages, division cell chain, output word
// depends on qtrm_pkg, qtrm_front, qtrm_div_cell
//
// channel  | dir | tdata                              | tuser
// s        | in  | quat_w, quat_x, quat_y, quat_z     | -
// m        | out | m00 m01 m02 m10 m11 m12 m20 m21 m22 | zero_error
//
// one word in and one out per cycle while the output word is not stalled
// the row of FRAC_BITS+1 division cells produces one quotient bit each
// the whole pipeline moves only while the output word is empty or being taken
// reset clears the valid line only; data registers are not reset
`timescale 1ns / 1ps
module quaternion_to_rotation_matrix
    import qtrm_pkg::*;
#(
    parameter int IN_WIDTH  = 16,
    parameter int FRAC_BITS = 14
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // quat_w, quat_x, quat_y, quat_z from bit 0 up, zero padded to bytes
    input  logic [((4*IN_WIDTH+7)/8)*8-1:0]        i_s_tdata,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
    output logic [N_ENTRY*OUT_W-1:0]               o_m_tdata,
    // zero_error
    output logic                                   o_m_tuser
);
    localparam int NCELL = FRAC_BITS + 1;
    localparam int LAT   = 5 + NCELL;

    logic w_en;
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    // valid and zero flag travel beside the data
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_zero;
    logic           w_zin;
    assign w_zin = (i_s_tdata[4*IN_WIDTH-1:0] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero <= {r_zero[LAT-2:0], w_zin};
        end
    end

    t_mag               w_n   [N_ENTRY][NCELL+1];
    t_mag               w_rem [N_ENTRY][NCELL+1];
    logic [FRAC_BITS:0] w_low [N_ENTRY][NCELL+1];
    logic [FRAC_BITS:0] w_q   [N_ENTRY][NCELL+1];
    logic               w_neg [N_ENTRY][NCELL+1];
    t_mag               w_fn;
    t_mag               w_frem [N_ENTRY];
    logic [FRAC_BITS:0] w_flow [N_ENTRY];
    logic [N_ENTRY-1:0] w_fneg;

    qtrm_front #(
        .IN_WIDTH  (IN_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_w   (i_s_tdata[0*IN_WIDTH +: IN_WIDTH]),
        .i_x   (i_s_tdata[1*IN_WIDTH +: IN_WIDTH]),
        .i_y   (i_s_tdata[2*IN_WIDTH +: IN_WIDTH]),
        .i_z   (i_s_tdata[3*IN_WIDTH +: IN_WIDTH]),
        .o_n   (w_fn),
        .o_rem (w_frem),
        .o_low (w_flow),
        .o_neg (w_fneg)
    );

    for (genvar e = 0; e < N_ENTRY; e++) begin : g_lane
        assign w_n[e][0]   = w_fn;
        assign w_rem[e][0] = w_frem[e];
        assign w_low[e][0] = w_flow[e];
        assign w_q[e][0]   = '0;
        assign w_neg[e][0] = w_fneg[e];
        for (genvar b = 0; b < NCELL; b++) begin : g_cell
            qtrm_div_cell #(
                .FRAC_BITS (FRAC_BITS)
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_n   (w_n[e][b]),
                .i_rem (w_rem[e][b]),
                .i_low (w_low[e][b]),
                .i_q   (w_q[e][b]),
                .i_neg (w_neg[e][b]),
                .o_n   (w_n[e][b+1]),
                .o_rem (w_rem[e][b+1]),
                .o_low (w_low[e][b+1]),
                .o_q   (w_q[e][b+1]),
                .o_neg (w_neg[e][b+1])
            );
        end
    end

    // sign back, identity when the quaternion was zero
    logic [N_ENTRY*OUT_W-1:0] n_data;
    logic [31:0]              w_one;
    logic [31:0]              w_qx;
    logic [31:0]              w_sv;

    always_comb begin
        w_one  = 32'd1 << FRAC_BITS;
        n_data = '0;
        for (int e = 0; e < N_ENTRY; e++) begin
            w_qx = 32'(w_q[e][NCELL]);
            w_sv = w_neg[e][NCELL] ? (~w_qx + 32'd1) : w_qx;
            if (r_zero[LAT-1]) begin
                w_sv = (e == 0 || e == 4 || e == 8) ? w_one : 32'd0;
            end
            n_data[e*OUT_W +: OUT_W] = w_sv[OUT_W-1:0];
        end
    end

    logic r_m_tvalid;
    logic [N_ENTRY*OUT_W-1:0] r_m_tdata;
    logic r_m_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_en) begin
            r_m_tvalid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_tdata <= n_data;
            r_m_tuser <= r_zero[LAT-1];
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;
endmodule

// ----- sv/qtrm_checker.sv -----
// qtrm_checker: port-level checks for quaternion_to_rotation_matrix, bound to the top level
// depends on qtrm_pkg
`timescale 1ns / 1ps
module qtrm_checker
    import qtrm_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_s_tready,
    input logic                       o_m_tvalid,
    input logic                       i_m_tready,
    input logic [N_ENTRY*OUT_W-1:0]   o_m_tdata,
    input logic                       o_m_tuser
);
    // output word held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output word changed while stalled");

    // input side only stalls when the output word is stuck
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output stall");

    // zero quaternion gives zero entries m01, m10, m12 and m21
    a_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            o_m_tdata[1*OUT_W +: OUT_W] == '0 && o_m_tdata[3*OUT_W +: OUT_W] == '0 &&
            o_m_tdata[5*OUT_W +: OUT_W] == '0 && o_m_tdata[7*OUT_W +: OUT_W] == '0)
        else $error("zero quaternion without identity matrix");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
endmodule

bind quaternion_to_rotation_matrix qtrm_checker u_qtrm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ----- tb/quaternion_to_rotation_matrix_tb.sv -----
// quaternion_to_rotation_matrix_tb: drives quaternions through the stream input and
// checks every matrix word against a predictor of the rounded, normalized matrix
// depends on qtrm_pkg and quaternion_to_rotation_matrix
`timescale 1ns / 1ps
module quaternion_to_rotation_matrix_tb;
    import qtrm_pkg::*;

    localparam int IN_W      = 16;
    localparam int FRAC      = 14;
    localparam int N_RANDOM  = 500;
    localparam int LATENCY   = FRAC + 7;
    localparam int MAX_CYC   = 400000;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic signed [15:0] w;
    } t_quat;

    typedef struct {
        logic [N_ENTRY*OUT_W-1:0] mat;
        logic                     zero_err;
    } t_matrix;

    typedef struct {
        t_quat q;
        bit    has_mat;   // expected matrix typed in the table
        logic  [N_ENTRY*OUT_W-1:0] mat;
        logic  zero_err;
    } t_row;

    localparam logic [15:0] ONE_Q = 16'sd16384;
    localparam logic [N_ENTRY*OUT_W-1:0] IDENT = {ONE_Q, 16'd0, 16'd0, 16'd0, ONE_Q,
                                                  16'd0, 16'd0, 16'd0, ONE_Q};
    localparam logic [15:0] M_ONE = -16'sd16384;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [N_ENTRY*OUT_W-1:0] o_m_tdata;
    logic o_m_tuser;

    quaternion_to_rotation_matrix #(.IN_WIDTH(IN_W), .FRAC_BITS(FRAC)) dut (.*);

    always #5 i_clk = ~i_clk;

    t_matrix expected_mats[$];
    int errors = 0;
    int words_seen = 0;
    int zero_seen = 0;
    int cycles = 0;
    bit recv_on = 1'b0;

    // round(|num| * 2^FRAC / n) half away from zero, capped at 2^FRAC, sign put back
    function automatic logic [15:0] entry_q(longint num, longint n);
        longint mag, q;
        mag = num < 0 ? -num : num;
        q = ((mag <<< FRAC) + (n >>> 1)) / n;
        if (q > (64'sd1 <<< FRAC)) q = 64'sd1 <<< FRAC;
        if (num < 0) q = -q;
        return q[15:0];
    endfunction

    function automatic t_matrix rotation_of(t_quat q);
        t_matrix r;
        longint w, x, y, z, ww, xx, yy, zz, n;
        w = q.w; x = q.x; y = q.y; z = q.z;
        ww = w*w; xx = x*x; yy = y*y; zz = z*z;
        n = ww + xx + yy + zz;
        if (n == 0) begin
            r.mat = IDENT;
            r.zero_err = 1'b1;
            return r;
        end
        r.mat = {entry_q(ww-xx-yy+zz, n), entry_q(2*(y*z+x*w), n), entry_q(2*(x*z-y*w), n),
                 entry_q(2*(y*z-x*w), n), entry_q(ww-xx+yy-zz, n), entry_q(2*(x*y+z*w), n),
                 entry_q(2*(x*z+y*w), n), entry_q(2*(x*y-z*w), n), entry_q(ww+xx-yy-zz, n)};
        r.zero_err = 1'b0;
        return r;
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    t_row dir_rows[$];

    task automatic add_row(int w, int x, int y, int z, bit typed,
                           logic [N_ENTRY*OUT_W-1:0] m, logic ze);
        t_row r;
        r.q = {16'(z), 16'(y), 16'(x), 16'(w)};
        r.has_mat = typed;
        r.mat = m;
        r.zero_err = ze;
        dir_rows.push_back(r);
    endtask

    task automatic send_quat(t_row r);
        t_matrix e;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= r.q;
        e = rotation_of(r.q);
        if (r.has_mat) begin
            e.mat = r.mat;
            e.zero_err = r.zero_err;
        end
        do @(posedge i_clk); while (!o_s_tready);
        expected_mats.push_back(e);
    endtask

    // sink: random stalls, compare each taken word with the oldest expectation
    initial begin
        int stall;
        t_matrix e;
        wait (recv_on);
        forever begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            words_seen++;
            if (expected_mats.size() == 0) begin
                errors++;
                $display("%0t unexpected word: expected none, actual %h/%b",
                         $time, o_m_tdata, o_m_tuser);
            end else begin
                e = expected_mats.pop_front();
                if (o_m_tuser) zero_seen++;
                for (int k = 0; k < N_ENTRY; k++)
                    if (o_m_tdata[k*16 +: 16] !== e.mat[k*16 +: 16]) begin
                        errors++;
                        $display("%0t entry %0d: expected %0d actual %0d", $time, k,
                                 $signed(e.mat[k*16 +: 16]),
                                 $signed(o_m_tdata[k*16 +: 16]));
                    end
                if (o_m_tuser !== e.zero_err) begin
                    errors++;
                    $display("%0t zero_error: expected %b actual %b",
                             $time, e.zero_err, o_m_tuser);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_row r;
        int drain;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        recv_on = 1'b1;

        // zero quaternion gives identity and the error flag; scalar-only ones give identity without it
        add_row(0, 0, 0, 0, 1, IDENT, 1'b1);
        add_row(1, 0, 0, 0, 1, IDENT, 1'b0);
        add_row(-32768, 0, 0, 0, 1, IDENT, 1'b0);
        add_row(32767, 0, 0, 0, 1, IDENT, 1'b0);
        // half turns about each axis
        add_row(0, 1, 0, 0, 1, {M_ONE, 16'd0, 16'd0, 16'd0, M_ONE,
                                16'd0, 16'd0, 16'd0, ONE_Q}, 1'b0);
        add_row(0, 0, -32768, 0, 1, {M_ONE, 16'd0, 16'd0, 16'd0, ONE_Q,
                                     16'd0, 16'd0, 16'd0, M_ONE}, 1'b0);
        add_row(0, 0, 0, 32767, 1, {ONE_Q, 16'd0, 16'd0, 16'd0, M_ONE,
                                    16'd0, 16'd0, 16'd0, M_ONE}, 1'b0);
        add_row(-32768, -32768, -32768, -32768, 0, '0, 0);
        add_row(32767, 32767, 32767, 32767, 0, '0, 0);
        add_row(32767, -32768, 32767, -32768, 0, '0, 0);
        add_row(1, 1, 0, 0, 0, '0, 0);
        add_row(1, 1, 1, 1, 0, '0, 0);
        add_row(-1, 2, -3, 4, 0, '0, 0);
        add_row(3, 1, 1, 1, 0, '0, 0);
        add_row(0, 32767, -32768, 1, 0, '0, 0);
        add_row(-32768, 0, 0, 32767, 0, '0, 0);
        foreach (dir_rows[i]) send_quat(dir_rows[i]);

        for (int i = 0; i < N_RANDOM; i++) begin
            r.q = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
            if ($urandom_range(0, 40) == 0) r.q = '0;
            r.has_mat = 1'b0;
            send_quat(r);
        end
        i_s_tvalid <= 1'b0;

        while (expected_mats.size() != 0) @(posedge i_clk);
        drain = 0;
        while (drain < 4 * LATENCY) begin
            @(posedge i_clk);
            drain++;
        end
        $display("covered %0d directed and %0d random quaternions, %0d words checked",
                 dir_rows.size(), N_RANDOM, words_seen);
        $display("zero quaternions seen on output: %0d", zero_seen);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
